// ===== rtl/fsp_pkg.sv =====
// Shared types, character codes and lookups for the format specifier parser.
`timescale 1ns / 1ps

package fsp_pkg;

    // Width of the width and precision accumulators; they saturate at all ones
    localparam int NUMBER_BITS = 16;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TERM    = 2'd0,
        KIND_LITERAL = 2'd1,
        KIND_SPEC    = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    // Parser phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_PCT   = 6'b000010,
        PH_FLAG  = 6'b000100,
        PH_WIDTH = 6'b001000,
        PH_DOT   = 6'b010000,
        PH_FRAC  = 6'b100000
    } phase_t;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_DEL   = 8'hFF;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_APOS  = 8'h27;

    // Lead padding codes
    localparam logic [1:0] LEAD_SPACE = 2'd1;
    localparam logic [1:0] LEAD_ZERO  = 2'd2;

    // One result item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  literal_char;
        logic [3:0]  conv_type;
        logic [2:0]  sign_flags;
        logic [1:0]  lead_mode;
        logic [15:0] field_width;
        logic        var_width;
        logic [15:0] precision;
        logic        var_precision;
        logic [7:0]  consumed;
        logic        last;
    } result_t;

    // Map a conversion letter to its index in "cdeEfgGilLosuxX"; bit 4 is the hit
    function automatic logic [4:0] conv_lookup(input logic [7:0] c);
        logic [4:0] res;
        begin
            case (c)
                8'h63:   res = {1'b1, 4'd0};   // c
                8'h64:   res = {1'b1, 4'd1};   // d
                8'h65:   res = {1'b1, 4'd2};   // e
                8'h45:   res = {1'b1, 4'd3};   // E
                8'h66:   res = {1'b1, 4'd4};   // f
                8'h67:   res = {1'b1, 4'd5};   // g
                8'h47:   res = {1'b1, 4'd6};   // G
                8'h69:   res = {1'b1, 4'd7};   // i
                8'h6C:   res = {1'b1, 4'd8};   // l
                8'h4C:   res = {1'b1, 4'd9};   // L
                8'h6F:   res = {1'b1, 4'd10};  // o
                8'h73:   res = {1'b1, 4'd11};  // s
                8'h75:   res = {1'b1, 4'd12};  // u
                8'h78:   res = {1'b1, 4'd13};  // x
                8'h58:   res = {1'b1, 4'd14};  // X
                default: res = 5'd0;
            endcase
            return res;
        end
    endfunction

endpackage

// ===== rtl/format_specifier_parser_core.sv =====
// Top level of the format specifier parser: decode, accumulators and result queue.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: char_in
//  m_      | out | m_tvalid/m_tready  | m_tdata: spec fields, m_tuser: kind,
//          |     |                    | m_tlast: last result of an input item
//
// One character is decoded per cycle while s_tready is high; its results are
// registered into a three-entry result queue and appear on m_ once those ahead are taken.
// An item that ends a specifier with an error and restarts on a literal or
// terminator gives two results, the error and then the restart result.
// s_tready is high while at most one result waits; the queue depth sets this.
// Reset clears the phase, all accumulators and the queue fill count.
`timescale 1ns / 1ps

module format_specifier_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] literal_char, [11:8] conv_type, [14:12] sign_flags, [16:15] lead_mode,
    // [32:17] field_width, [33] var_width, [49:34] precision, [50] var_precision,
    // [58:51] consumed, [63:59] zero
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    // Parser state
    fsp_pkg::phase_t                     phase_reg, phase_next;
    logic [2:0]                          sign_reg, sign_next;
    logic [1:0]                          lead_reg, lead_next;
    logic [fsp_pkg::NUMBER_BITS-1:0]     width_reg, width_next;
    logic                                vw_reg, vw_next;
    logic [fsp_pkg::NUMBER_BITS-1:0]     prec_reg, prec_next;
    logic                                vp_reg, vp_next;
    logic [7:0]                          count_reg, count_next;

    // Result queue
    fsp_pkg::result_t q_reg [0:2];
    fsp_pkg::result_t q_next [0:2];
    logic [1:0]       fill_reg, fill_next;

    // Decode signals
    logic [7:0]       c;
    logic             accept, pop;
    logic             is_term, is_pct, is_star, is_dot, is_digit, is_d19, is_flag, conv_hit;
    logic [3:0]       conv_idx;
    logic [7:0]       count_inc;
    logic [fsp_pkg::NUMBER_BITS-1:0] width_add, prec_add;
    fsp_pkg::result_t start_res, spec_res, err_res, pct_res, res0, res1;
    logic             start_hit, do_fail, do_start, do_finish;
    logic [1:0]       n_res, base;

    // Add one decimal digit to a saturating accumulator
    function automatic logic [fsp_pkg::NUMBER_BITS-1:0] add_digit(
        input logic [fsp_pkg::NUMBER_BITS-1:0] v,
        input logic [7:0]                      ch
    );
        logic [fsp_pkg::NUMBER_BITS+3:0] sum;
        begin
            sum = ({4'b0000, v} << 3) + ({4'b0000, v} << 1)
                + (fsp_pkg::NUMBER_BITS+4)'(ch[3:0]);
            if (sum[fsp_pkg::NUMBER_BITS+3:fsp_pkg::NUMBER_BITS] != 4'd0)
                return '1;
            return sum[fsp_pkg::NUMBER_BITS-1:0];
        end
    endfunction

    // Take the low 16 bits of an accumulator, zero extended if narrower
    function automatic logic [15:0] low16(input logic [fsp_pkg::NUMBER_BITS-1:0] v);
        logic [fsp_pkg::NUMBER_BITS+15:0] ext;
        begin
            ext = {16'd0, v};
            return ext[15:0];
        end
    endfunction

    assign c        = s_tdata;
    assign s_tready = (fill_reg <= 2'd1);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (fill_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;

    // Classify the character
    always_comb
    begin
        is_term  = (c == fsp_pkg::CHAR_NUL) || (c == fsp_pkg::CHAR_DEL);
        is_pct   = (c == fsp_pkg::CHAR_PCT);
        is_star  = (c == fsp_pkg::CHAR_STAR);
        is_dot   = (c == fsp_pkg::CHAR_DOT);
        is_digit = (c >= fsp_pkg::CHAR_ZERO) && (c <= fsp_pkg::CHAR_NINE);
        is_d19   = (c >= fsp_pkg::CHAR_ONE) && (c <= fsp_pkg::CHAR_NINE);
        is_flag  = (c == fsp_pkg::CHAR_PLUS) || (c == fsp_pkg::CHAR_MINUS)
                || (c == fsp_pkg::CHAR_SPACE) || (c == fsp_pkg::CHAR_HASH)
                || (c == fsp_pkg::CHAR_APOS) || (c == fsp_pkg::CHAR_ZERO);
        {conv_hit, conv_idx} = fsp_pkg::conv_lookup(c);
        count_inc = (count_reg == 8'hFF) ? 8'hFF : count_reg + 8'd1;
        width_add = add_digit(width_reg, c);
        prec_add  = add_digit(prec_reg, c);
    end

    // Build the candidate results
    always_comb
    begin
        start_res = '0;
        start_hit = 1'b1;
        if (is_term)
        begin
            start_res.kind         = fsp_pkg::KIND_TERM;
            start_res.literal_char = c;
        end
        else if (!is_pct)
        begin
            start_res.kind         = fsp_pkg::KIND_LITERAL;
            start_res.literal_char = c;
            start_res.consumed     = 8'd1;
        end
        else
        begin
            start_hit = 1'b0;
        end

        spec_res               = '0;
        spec_res.kind          = fsp_pkg::KIND_SPEC;
        spec_res.conv_type     = conv_idx;
        spec_res.sign_flags    = sign_reg;
        spec_res.lead_mode     = lead_reg;
        spec_res.field_width   = low16(width_reg);
        spec_res.var_width     = vw_reg;
        spec_res.precision     = low16(prec_reg);
        spec_res.var_precision = vp_reg;
        spec_res.consumed      = count_inc;

        err_res          = '0;
        err_res.kind     = fsp_pkg::KIND_ERROR;
        err_res.consumed = count_reg;

        pct_res              = '0;
        pct_res.kind         = fsp_pkg::KIND_LITERAL;
        pct_res.literal_char = fsp_pkg::CHAR_PCT;
        pct_res.consumed     = count_inc;
    end

    // Advance the parser for one character
    always_comb
    begin
        phase_next = phase_reg;
        sign_next  = sign_reg;
        lead_next  = lead_reg;
        width_next = width_reg;
        vw_next    = vw_reg;
        prec_next  = prec_reg;
        vp_next    = vp_reg;
        count_next = count_reg;
        res0       = start_res;
        res1       = '0;
        n_res      = 2'd0;
        do_fail    = 1'b0;
        do_start   = 1'b0;
        do_finish  = 1'b0;

        unique case (phase_reg)
            fsp_pkg::PH_IDLE:
            begin
                do_start = 1'b1;
            end
            fsp_pkg::PH_PCT:
            begin
                if (is_pct)
                begin
                    res0       = pct_res;
                    n_res      = 2'd1;
                    phase_next = fsp_pkg::PH_IDLE;
                    count_next = count_inc;
                end
                else if (conv_hit)
                    do_finish = 1'b1;
                else if (is_flag)
                    phase_next = fsp_pkg::PH_FLAG;
                else if (is_d19 || is_star)
                    phase_next = fsp_pkg::PH_WIDTH;
                else if (is_dot)
                begin
                    count_next = count_inc;
                    phase_next = fsp_pkg::PH_DOT;
                end
                else
                    do_fail = 1'b1;
            end
            fsp_pkg::PH_FLAG:
            begin
                if (is_d19 || is_star)
                    phase_next = fsp_pkg::PH_WIDTH;
                else if (conv_hit)
                    do_finish = 1'b1;
                else if (is_flag)
                    phase_next = fsp_pkg::PH_FLAG;
                else if (is_dot)
                begin
                    count_next = count_inc;
                    phase_next = fsp_pkg::PH_DOT;
                end
                else
                    do_fail = 1'b1;
            end
            fsp_pkg::PH_WIDTH:
            begin
                if (is_digit)
                    phase_next = fsp_pkg::PH_WIDTH;
                else if (conv_hit)
                    do_finish = 1'b1;
                else if (is_dot)
                begin
                    count_next = count_inc;
                    phase_next = fsp_pkg::PH_DOT;
                end
                else
                    do_fail = 1'b1;
            end
            fsp_pkg::PH_DOT:
            begin
                if (is_digit || is_star)
                    phase_next = fsp_pkg::PH_FRAC;
                else
                    do_fail = 1'b1;
            end
            fsp_pkg::PH_FRAC:
            begin
                if (is_digit)
                    phase_next = fsp_pkg::PH_FRAC;
                else if (conv_hit)
                    do_finish = 1'b1;
                else
                    do_fail = 1'b1;
            end
            default:
            begin
                do_start = 1'b1;
            end
        endcase

        // Apply a flag character
        if (phase_next == fsp_pkg::PH_FLAG && !do_fail)
        begin
            case (c)
                fsp_pkg::CHAR_PLUS:  sign_next[0] = 1'b1;
                fsp_pkg::CHAR_MINUS: sign_next[1] = 1'b1;
                fsp_pkg::CHAR_HASH:  sign_next[2] = 1'b1;
                fsp_pkg::CHAR_SPACE: lead_next    = fsp_pkg::LEAD_SPACE;
                fsp_pkg::CHAR_ZERO:  lead_next    = fsp_pkg::LEAD_ZERO;
                default:             lead_next    = lead_reg;
            endcase
            count_next = count_inc;
        end

        // Add to width: star marks it variable, digits still accumulate
        if (phase_next == fsp_pkg::PH_WIDTH)
        begin
            if (is_star)
                vw_next = 1'b1;
            else
                width_next = width_add;
            count_next = count_inc;
        end

        // Add to precision
        if (phase_next == fsp_pkg::PH_FRAC)
        begin
            if (is_star)
                vp_next = 1'b1;
            else
                prec_next = prec_add;
            count_next = count_inc;
        end

        // Close the specifier on a conversion letter
        if (do_finish)
        begin
            res0       = spec_res;
            n_res      = 2'd1;
            count_next = count_inc;
            phase_next = fsp_pkg::PH_IDLE;
        end

        // Drop the specifier with an error, then treat the byte as a new start
        if (do_fail)
        begin
            res0 = err_res;
            res1 = start_res;
            n_res = start_hit ? 2'd2 : 2'd1;
        end

        if (do_start)
            n_res = start_hit ? 2'd1 : 2'd0;

        // Begin a new specifier, or clear after an error
        if (do_fail || do_start)
        begin
            phase_next = fsp_pkg::PH_IDLE;
            if (do_fail || !start_hit)
            begin
                sign_next  = 3'd0;
                lead_next  = 2'd0;
                width_next = '0;
                vw_next    = 1'b0;
                prec_next  = '0;
                vp_next    = 1'b0;
                count_next = 8'd0;
            end
            if (!start_hit)
            begin
                count_next = 8'd1;
                phase_next = fsp_pkg::PH_PCT;
            end
        end

        // Mark the final result of this item
        if (n_res == 2'd1)
            res0.last = 1'b1;
        if (n_res == 2'd2)
            res1.last = 1'b1;
    end

    // Hold the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fsp_pkg::PH_IDLE;
            sign_reg  <= 3'd0;
            lead_reg  <= 2'd0;
            width_reg <= '0;
            vw_reg    <= 1'b0;
            prec_reg  <= '0;
            vp_reg    <= 1'b0;
            count_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            sign_reg  <= sign_next;
            lead_reg  <= lead_next;
            width_reg <= width_next;
            vw_reg    <= vw_next;
            prec_reg  <= prec_next;
            vp_reg    <= vp_next;
            count_reg <= count_next;
        end
    end

    // Shift out the head and append new results behind the waiting ones
    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        q_next[2] = q_reg[2];
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        base = fill_reg - {1'b0, pop};
        if (accept && n_res != 2'd0)
        begin
            if (base == 2'd0)
            begin
                q_next[0] = res0;
                q_next[1] = res1;
            end
            else
            begin
                q_next[1] = res0;
                q_next[2] = res1;
            end
        end
        fill_next = base + (accept ? n_res : 2'd0);
    end

    // Hold the queue fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 2'd0;
        else
            fill_reg <= fill_next;
    end

    // Hold the queue entries
    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
        q_reg[2] <= q_next[2];
    end

    // Pack the head entry onto the output
    assign m_tdata = {5'd0, q_reg[0].consumed, q_reg[0].var_precision, q_reg[0].precision,
                      q_reg[0].var_width, q_reg[0].field_width, q_reg[0].lead_mode,
                      q_reg[0].sign_flags, q_reg[0].conv_type, q_reg[0].literal_char};
    assign m_tuser = q_reg[0].kind;
    assign m_tlast = q_reg[0].last;

`ifndef SYNTHESIS
    // A specifier that has only seen its percent sign has consumed one byte
    a_pct_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == fsp_pkg::PH_PCT |-> count_reg == 8'd1)
        else $error("percent phase with wrong consumed count");

    // Two results only come from an error inside a specifier
    a_two_from_spec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && n_res == 2'd2 |-> phase_reg != fsp_pkg::PH_IDLE
                                    && res0.kind == fsp_pkg::KIND_ERROR)
        else $error("two results outside an error");

    // The restart result after an error is a terminator or a literal
    a_second_kind: assert property (@(posedge clk) disable iff (!rst_n)
        accept && n_res == 2'd2 |-> res1.kind == fsp_pkg::KIND_TERM
                                    || res1.kind == fsp_pkg::KIND_LITERAL)
        else $error("bad kind on restart result");

    // A result pushed into an empty queue is offered the next cycle
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        accept && n_res != 2'd0 && fill_reg == 2'd0 |=> m_tvalid)
        else $error("result lost from empty queue");
`endif

endmodule
